### rtl/core/srms_pkg.sv
// ----------------------------------------------------------------------------
// srms_pkg
// Shared types, constants and the sort-order compare for the range sorter.
// ----------------------------------------------------------------------------
package srms_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int KEY_WIDTH    = 32;
	localparam int TAG_WIDTH    = 16;
	localparam int CNT_WIDTH    = $clog2(MAX_ELEMENTS + 1);
	localparam int PHASE_WIDTH  = $clog2(MAX_ELEMENTS);
	localparam int CFG_WIDTH    = 7;
	localparam int CFG_IDX_W    = 2;
	localparam int DATA_WIDTH   = ((KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DESCENDING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_END   = 2'd2;

	typedef struct packed {
		logic [TAG_WIDTH-1:0]        tag;
		logic signed [KEY_WIDTH-1:0] key;
	} elem_t;

	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_SORT  = 2'd2,
		CELL_SHIFT = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       descending;
	} cell_ctrl_t;

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_SORT = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// True when a must strictly follow b in the sort order
	function automatic logic elem_after(input elem_t a, input elem_t b, input logic desc);
		logic lt;
		logic gt;
		lt = a.key < b.key;
		gt = a.key > b.key;
		return desc ? lt : gt;
	endfunction

endpackage

### rtl/core/stable_range_merge_sorter.sv
// Flow: the block accepts words until the one marked last, then the cell row
// runs its odd-even exchange passes, then streams one output word per cycle
// while m_tready is high; no new list is taken before the last word leaves.
// Throughput is set by the exchange passes of the cell row, one list at a time.
// Reset: arst_n clears count, overflow, state and registers (range_end to 64);
// cell contents are left as they are.
// ----------------------------------------------------------------------------
// stable_range_merge_sorter
// Collects a list, stably sorts a position range by signed key, and streams
// the whole list back out with last and overflow marks.
// ----------------------------------------------------------------------------
module stable_range_merge_sorter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [srms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srms_pkg::CFG_WIDTH-1:0]      cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [srms_pkg::DATA_WIDTH-1:0]     s_tdata,   // key, tag
	input  logic                                s_tlast,   // last
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [srms_pkg::DATA_WIDTH-1:0]     m_tdata,   // out_key, out_tag
	output logic                                m_tlast,   // out_last
	output logic                                m_tuser    // overflow
);
	import srms_pkg::*;

	state_t                 state_q;
	logic [CNT_WIDTH-1:0]   count_q;
	logic                   overflow_q;
	logic [PHASE_WIDTH-1:0] phase_q;
	logic                   descending_q;
	logic [CFG_WIDTH-1:0]   range_start_q;
	logic [CFG_WIDTH-1:0]   range_end_q;

	logic                   in_acc;
	logic                   out_acc;
	logic [CNT_WIDTH-1:0]   end_pos;
	elem_t                  din;
	cell_ctrl_t             ctrl;
	elem_t                  cell_data [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0] cell_swap;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tdata  = DATA_WIDTH'(cell_data[0]);
	assign m_tlast  = (count_q == CNT_WIDTH'(1));
	assign m_tuser  = overflow_q;

	assign din = elem_t'(s_tdata[KEY_WIDTH+TAG_WIDTH-1:0]);

	// Clamp the range end to the element count
	assign end_pos = (CNT_WIDTH'(range_end_q) < count_q) ? CNT_WIDTH'(range_end_q) : count_q;

	// Drive the cell row mode
	always_comb begin
		ctrl.descending = descending_q;
		case (state_q)
			ST_LOAD: ctrl.mode = in_acc ? CELL_LOAD : CELL_HOLD;
			ST_SORT: ctrl.mode = CELL_SORT;
			ST_EMIT: ctrl.mode = out_acc ? CELL_SHIFT : CELL_HOLD;
			default: ctrl.mode = CELL_HOLD;
		endcase
	end

	// Build the row of cells
	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic  load_sel;
		logic  pair_en;
		logic  left_swap;
		elem_t left;
		elem_t right;

		assign load_sel = (count_q == CNT_WIDTH'(i));

		if (i == 0) begin : g_first
			assign left      = '0;
			assign left_swap = 1'b0;
		end else begin : g_mid
			assign left      = cell_data[i-1];
			assign left_swap = cell_swap[i-1];
		end

		if (i == MAX_ELEMENTS - 1) begin : g_last
			assign right   = '0;
			assign pair_en = 1'b0;
		end else begin : g_pair
			assign right   = cell_data[i+1];
			assign pair_en = (phase_q[0] == 1'(i % 2))
				&& ((CNT_WIDTH+1)'(range_start_q) <= (CNT_WIDTH+1)'(i))
				&& ((CNT_WIDTH+1)'(i + 2) <= (CNT_WIDTH+1)'(end_pos));
		end

		srms_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_sel  (load_sel),
			.pair_en   (pair_en),
			.din       (din),
			.left      (left),
			.right     (right),
			.left_swap (left_swap),
			.data      (cell_data[i]),
			.swap      (cell_swap[i])
		);
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q  <= 1'b0;
			range_start_q <= '0;
			range_end_q   <= CFG_WIDTH'(MAX_ELEMENTS);
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_DESCENDING:  descending_q  <= cfg_wdata[0];
				REG_RANGE_START: range_start_q <= cfg_wdata;
				REG_RANGE_END:   range_end_q   <= cfg_wdata;
				default: begin
					descending_q <= descending_q;
				end
			endcase
		end
	end

	// Sequence load, exchange passes and emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			overflow_q <= 1'b0;
			phase_q    <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (count_q < CNT_WIDTH'(MAX_ELEMENTS)) begin
							count_q <= count_q + CNT_WIDTH'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (s_tlast) begin
							state_q <= ST_SORT;
							phase_q <= '0;
						end
					end
				end
				ST_SORT: begin
					phase_q <= phase_q + PHASE_WIDTH'(1);
					if (phase_q == PHASE_WIDTH'(MAX_ELEMENTS - 1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						count_q <= count_q - CNT_WIDTH'(1);
						if (count_q == CNT_WIDTH'(1)) begin
							overflow_q <= 1'b0;
							state_q    <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Input and output sides never open together
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input and output handshakes open at once");

	// Overflow only once the row is full
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(overflow_q && state_q == ST_LOAD) |-> (count_q == CNT_WIDTH'(MAX_ELEMENTS)))
		else $error("overflow set while room remains");

	// The final word returns the block to loading with an empty list
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && m_tlast) |=> (state_q == ST_LOAD && count_q == '0 && !overflow_q))
		else $error("list not cleared after final word");

	// Emission never runs on an empty list
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (count_q != '0))
		else $error("emitting with empty list");

endmodule

### rtl/core/srms_cell.sv
// ----------------------------------------------------------------------------
// srms_cell
// One slot of the sorting row: holds an element, compares it with its right
// neighbor and trades places on a swap, loads and shifts toward the output.
// ----------------------------------------------------------------------------
module srms_cell (
	input  logic                clk,
	input  srms_pkg::cell_ctrl_t ctrl,
	input  logic                load_sel,
	input  logic                pair_en,
	input  srms_pkg::elem_t     din,
	input  srms_pkg::elem_t     left,
	input  srms_pkg::elem_t     right,
	input  logic                left_swap,
	output srms_pkg::elem_t     data,
	output logic                swap
);
	import srms_pkg::*;

	elem_t data_q;

	assign data = data_q;

	// Flag a swap with the right neighbor when this pair is out of order
	assign swap = pair_en && (ctrl.mode == CELL_SORT) && elem_after(data_q, right, ctrl.descending);

	// Load, trade places, shift or hold
	always_ff @(posedge clk) begin
		case (ctrl.mode)
			CELL_LOAD: begin
				if (load_sel) begin
					data_q <= din;
				end
			end
			CELL_SORT: begin
				if (left_swap) begin
					data_q <= left;
				end else if (swap) begin
					data_q <= right;
				end
			end
			CELL_SHIFT: begin
				data_q <= right;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule
